// ----- hdl/i2cm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_RDACK = 3'd5;
  localparam logic [2:0] OP_WRACK = 3'd6;

  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_DATA_OFFSET = 1'b1;

  localparam logic [7:0] HALF_PERIOD_RST = 8'd5;
  localparam logic [7:0] DATA_OFFSET_RST = 8'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } out_item_t;

  // Classified item as it travels from the front end to the engine.
  typedef struct packed {
    logic       is_tick;
    logic       is_cmd;
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } cls_item_t;

endpackage

// ----- hdl/i2cm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Input front end: takes transfers and classifies them as tick, command or
// no-op before they enter the queue.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cm_pkg::in_item_t  in_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output i2cm_pkg::cls_item_t q_item_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.is_tick   = (in_data_i.opcode == i2cm_pkg::OP_TICK);
    q_item_o.is_cmd    = (in_data_i.opcode >= i2cm_pkg::OP_START) &&
                         (in_data_i.opcode <= i2cm_pkg::OP_WRACK);
    q_item_o.opcode    = in_data_i.opcode;
    q_item_o.data_byte = in_data_i.data_byte;
    q_item_o.ack_level = in_data_i.ack_level;
    q_item_o.sda_in    = in_data_i.sda_in;
  end

endmodule

// ----- hdl/i2cm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_queue
// Two-entry queue between the front end and the engine.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
module i2cm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  i2cm_pkg::cls_item_t push_item_i,
  output logic                full_o,
  output logic                valid_o,
  output i2cm_pkg::cls_item_t pop_item_o,
  input  logic                pop_i
);

  i2cm_pkg::cls_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- hdl/i2cm_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// Back end: holds the bus timing registers, runs the command sequences on
// ticks and registers one status transfer per item.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                q_valid_i,
  input  i2cm_pkg::cls_item_t q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cm_pkg::out_item_t out_data_o
);

  logic [7:0] half_q, offset_q;

  logic [2:0] act_q, act_d;
  logic       phase_q, phase_d;
  logic [7:0] cnt_q, cnt_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] rx_q, rx_d;
  logic       ack_q, ack_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       drv_q, drv_d;
  logic       ackout_q, ackout_d;

  logic                out_valid_q;
  i2cm_pkg::out_item_t out_data_q, out_data_d;

  logic [7:0] h, d, c;
  logic [3:0] nb, slots;
  logic       writer, reader, done, rej;

  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    h      = (half_q == 8'd0) ? 8'd1 : half_q;
    d      = (offset_q >= h) ? (h - 8'd1) : offset_q;
    writer = (act_q == i2cm_pkg::OP_WRITE) || (act_q == i2cm_pkg::OP_WRACK);
    reader = (act_q == i2cm_pkg::OP_READ);
    slots  = (reader || act_q == i2cm_pkg::OP_WRITE) ?
             4'(i2cm_pkg::BITS_PER_BYTE) : 4'd1;
    c      = cnt_q + 8'd1;
    nb     = bit_q + 4'd1;

    act_d    = act_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    rx_d     = rx_q;
    ack_d    = ack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    drv_d    = drv_q;
    ackout_d = ackout_q;
    done     = 1'b0;
    rej      = 1'b0;

    if (q_item_i.is_tick) begin
      if (act_q != i2cm_pkg::OP_TICK) begin
        cnt_d = c;
        if (act_q == i2cm_pkg::OP_START || act_q == i2cm_pkg::OP_STOP) begin
          if (c >= h) begin
            cnt_d = 8'd0;
            if (!phase_q) begin
              phase_d = 1'b1;
              if (act_q == i2cm_pkg::OP_START) sda_d = 1'b0;
              else scl_d = 1'b1;
            end else begin
              if (act_q == i2cm_pkg::OP_START) scl_d = 1'b0;
              else sda_d = 1'b1;
              done = 1'b1;
            end
          end
        end else if (!phase_q) begin
          if (c == d && writer) begin
            sda_d = (act_q == i2cm_pkg::OP_WRITE) ? shift_q[7] : ackout_q;
          end
          if (c >= h) begin
            scl_d   = 1'b1;
            phase_d = 1'b1;
            cnt_d   = 8'd0;
            if (d == 8'd0 && !writer) begin
              if (reader) shift_d = {shift_q[6:0], q_item_i.sda_in};
              else ack_d = q_item_i.sda_in;
            end
          end
        end else begin
          if (c == d && !writer) begin
            if (reader) shift_d = {shift_q[6:0], q_item_i.sda_in};
            else ack_d = q_item_i.sda_in;
          end
          if (c >= h) begin
            scl_d   = 1'b0;
            phase_d = 1'b0;
            cnt_d   = 8'd0;
            if (act_q == i2cm_pkg::OP_WRITE) shift_d = {shift_q[6:0], 1'b0};
            bit_d = nb;
            if (nb >= slots) begin
              if (reader) rx_d = shift_d;
              done = 1'b1;
            end else if (d == 8'd0 && writer) begin
              sda_d = (act_q == i2cm_pkg::OP_WRITE) ? shift_d[7] : ackout_q;
            end
          end
        end
        if (done) act_d = i2cm_pkg::OP_TICK;
      end
    end else if (q_item_i.is_cmd) begin
      if (act_q != i2cm_pkg::OP_TICK) begin
        rej = 1'b1;
      end else begin
        act_d   = q_item_i.opcode;
        phase_d = 1'b0;
        cnt_d   = 8'd0;
        bit_d   = 4'd0;
        unique case (q_item_i.opcode)
          i2cm_pkg::OP_START: begin
            drv_d = 1'b1; scl_d = 1'b1; sda_d = 1'b1;
          end
          i2cm_pkg::OP_STOP: begin
            drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
          end
          i2cm_pkg::OP_WRITE, i2cm_pkg::OP_WRACK: begin
            shift_d  = q_item_i.data_byte;
            ackout_d = q_item_i.ack_level;
            drv_d    = 1'b1;
            scl_d    = 1'b0;
            if (d == 8'd0) begin
              sda_d = (q_item_i.opcode == i2cm_pkg::OP_WRITE) ?
                      q_item_i.data_byte[7] : q_item_i.ack_level;
            end
          end
          default: begin
            shift_d = 8'd0;
            drv_d   = 1'b0;
            scl_d   = 1'b0;
          end
        endcase
      end
    end

    out_data_d.scl_level = scl_d;
    out_data_d.sda_level = sda_d;
    out_data_d.sda_drive = drv_d;
    out_data_d.busy_res  = (act_d != i2cm_pkg::OP_TICK);
    out_data_d.done_res  = done;
    out_data_d.rx_byte   = rx_d;
    out_data_d.ack_seen  = ack_d;
    out_data_d.rejected  = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= i2cm_pkg::HALF_PERIOD_RST;
      offset_q <= i2cm_pkg::DATA_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cm_pkg::CFG_HALF_PERIOD: half_q   <= cfg_data_i;
        i2cm_pkg::CFG_DATA_OFFSET: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= i2cm_pkg::OP_TICK;
      phase_q     <= 1'b0;
      cnt_q       <= 8'd0;
      bit_q       <= 4'd0;
      shift_q     <= 8'd0;
      rx_q        <= 8'd0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      ackout_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        act_q    <= act_d;
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        bit_q    <= bit_d;
        shift_q  <= shift_d;
        rx_q     <= rx_d;
        ack_q    <= ack_d;
        scl_q    <= scl_d;
        sda_q    <= sda_d;
        drv_q    <= drv_d;
        ackout_q <= ackout_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ----- hdl/i2c_master_bit_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master pin sequencer: command and tick transfers in, one status
// transfer out for each.
// ----------------------------------------------------------------------------
// Takes one transfer per clock and returns one status transfer per clock when
// neither side stalls. A transfer passes the classifier into a two-entry
// queue, the engine updates the bus state from it and the status sits in an
// output register, so the status is valid once the transfer has passed the
// queue and the output register. The engine handles one item per clock while
// its output is not stalled. The configuration registers act on the next
// tick; write them only while no transfer is outstanding.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cm_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);

  logic                q_full, q_push, q_valid, q_pop;
  i2cm_pkg::cls_item_t push_item, pop_item;

  i2cm_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  i2cm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item),
    .pop_i       (q_pop)
  );

  i2cm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
